// File: src/aes128_pkg.sv
// shared types, constants and round functions for the aes-128 core
package aes128_pkg;

    typedef logic [127:0] t_block;
    typedef logic [31:0]  t_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        REG_KEY_HIGH = 2'd0,
        REG_KEY_LOW  = 2'd1,
        REG_MODE     = 2'd2
    } t_reg_idx;

    localparam int NUM_ROUNDS = 10;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_word mix_col(input t_word w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    function automatic t_word inv_mix_col(input t_word w);
        logic [7:0] a0, a1, a2, a3, u, v;
        t_word p;
        a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        p = {a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v};
        return mix_col(p);
    endfunction

    function automatic t_word sub_word(input t_word w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

// File: src/aes128_key_exp.sv
// round key expansion, one round key per cycle into a 44-word store
module aes128_key_exp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [127:0]         i_key,
    input  logic [3:0]           i_rd_round,
    output aes128_pkg::t_block   o_rd_key,
    output logic                 o_busy
);

    logic [127:0] r_store [11];
    logic [127:0] r_cur;
    logic [3:0]   r_cnt;
    logic         r_busy;
    logic [127:0] n_next;
    aes128_pkg::t_word t0, w0, w1, w2, w3;

    always_comb begin
        t0 = aes128_pkg::sub_word({r_cur[23:0], r_cur[31:24]})
             ^ {aes128_pkg::RCON[r_cnt - 4'd1], 24'h0};
        w0 = r_cur[127:96] ^ t0;
        w1 = r_cur[95:64] ^ w0;
        w2 = r_cur[63:32] ^ w1;
        w3 = r_cur[31:0] ^ w2;
        n_next = {w0, w1, w2, w3};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= 4'd1;
            r_cur  <= '0;
            r_store[0] <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 4'd1;
            r_cur  <= i_key;
            r_store[0] <= i_key;
        end else if (r_busy) begin
            r_store[r_cnt] <= n_next;
            r_cur <= n_next;
            if (r_cnt == 4'(aes128_pkg::NUM_ROUNDS)) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 4'd1;
        end
    end

    assign o_rd_key = r_store[i_rd_round];
    assign o_busy   = r_busy;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt >= 4'd1 && r_cnt <= 4'(aes128_pkg::NUM_ROUNDS)))
        else $error("key counter out of range");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("expansion did not start");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(r_cnt) == 4'(aes128_pkg::NUM_ROUNDS))
        else $error("expansion ended early");
`endif

endmodule

// File: src/aes128_block_cipher_core.sv
// aes-128 ecb core with iterative round unit
// channel | dir | handshake         | payload
// in      | in  | i_valid / o_stall | i_block_high, i_block_low
// out     | out | o_valid / i_stall | o_result_high, o_result_low
// cfg     | in  | i_cfg_we          | i_cfg_idx, i_cfg_data
// one transaction runs in order: load with key addition, ten rounds of the shared
// round unit, then the result register; key expansion runs after reset or
// any key write, and input is stalled until it completes.
// input is stalled while a block is in flight or its result waits under i_stall.
module aes128_block_cipher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low
);

    aes128_pkg::t_state r_state, n_state;
    logic [63:0]  r_key_hi, r_key_lo;
    logic         r_dec;
    logic         r_kstart;
    logic [127:0] r_s;
    logic [3:0]   r_rnd;
    logic [3:0]   rd_round;
    logic         kbusy;
    aes128_pkg::t_block rk, rk_imc, n_s, t_sub;
    logic         last;
    logic         accept;

    aes128_key_exp u_kexp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_kstart),
        .i_key      ({r_key_hi, r_key_lo}),
        .i_rd_round (rd_round),
        .o_rd_key   (rk),
        .o_busy     (kbusy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_dec    <= 1'b0;
            r_kstart <= 1'b0;
        end else begin
            r_kstart <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    aes128_pkg::REG_KEY_HIGH: begin
                        r_key_hi <= i_cfg_data;
                        r_kstart <= 1'b1;
                    end
                    aes128_pkg::REG_KEY_LOW: begin
                        r_key_lo <= i_cfg_data;
                        r_kstart <= 1'b1;
                    end
                    aes128_pkg::REG_MODE: r_dec <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != aes128_pkg::ST_IDLE) || kbusy || r_kstart;
    assign last    = (r_rnd == 4'(aes128_pkg::NUM_ROUNDS));

    // round key select: encrypt walks up, decrypt walks down
    always_comb begin
        if (r_state == aes128_pkg::ST_IDLE) begin
            rd_round = r_dec ? 4'(aes128_pkg::NUM_ROUNDS) : 4'd0;
        end else begin
            rd_round = r_dec ? 4'(aes128_pkg::NUM_ROUNDS) - r_rnd : r_rnd;
        end
    end

    // shared round unit
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (r_dec) begin
                    t_sub[127 - 8*(4*((c + r) % 4) + r) -: 8] =
                        aes128_pkg::INV_SBOX[r_s[127 - 8*(4*c + r) -: 8]];
                end else begin
                    t_sub[127 - 8*(4*c + r) -: 8] =
                        aes128_pkg::SBOX[r_s[127 - 8*(4*((c + r) % 4) + r) -: 8]];
                end
            end
        end
        for (int c = 0; c < 4; c++) begin
            rk_imc[127 - 32*c -: 32] = aes128_pkg::inv_mix_col(rk[127 - 32*c -: 32]);
        end
        n_s = t_sub;
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                n_s[127 - 32*c -: 32] = r_dec
                    ? aes128_pkg::inv_mix_col(t_sub[127 - 32*c -: 32])
                    : aes128_pkg::mix_col(t_sub[127 - 32*c -: 32]);
            end
            n_s = n_s ^ (r_dec ? rk_imc : rk);
        end else begin
            n_s = n_s ^ rk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aes128_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            aes128_pkg::ST_IDLE: if (accept) n_state = aes128_pkg::ST_RUN;
            aes128_pkg::ST_RUN:  if (last) n_state = aes128_pkg::ST_DONE;
            aes128_pkg::ST_DONE: if (!i_stall) n_state = aes128_pkg::ST_IDLE;
            default:             n_state = aes128_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd <= 4'd1;
        end else if (accept) begin
            r_rnd <= 4'd1;
        end else if (r_state == aes128_pkg::ST_RUN) begin
            r_rnd <= r_rnd + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s <= {i_block_high, i_block_low} ^ rk;
        end else if (r_state == aes128_pkg::ST_RUN) begin
            r_s <= n_s;
        end
    end

    assign o_valid       = (r_state == aes128_pkg::ST_DONE);
    assign o_result_high = r_s[127:64];
    assign o_result_low  = r_s[63:0];

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aes128_pkg::ST_RUN) |-> o_stall)
        else $error("input taken mid-run");
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aes128_pkg::ST_RUN) |-> (r_rnd >= 4'd1 && r_rnd <= 4'd10))
        else $error("round counter out of range");
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(last))
        else $error("result without final round");
    a_keys_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aes128_pkg::ST_RUN) |-> !kbusy)
        else $error("round keys changing during run");
`endif

endmodule
